FILE: rtl/ordered_list_push_front_remove_defines.svh
// ----------------------------------------------------------------------------
// ordered_list_push_front_remove_defines.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_PUSH_FRONT_REMOVE_DEFINES_SVH
`define ORDERED_LIST_PUSH_FRONT_REMOVE_DEFINES_SVH

// property checked at every edge outside reset
`define OPLFR_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("oplfr checker: property failed");

// property that also covers the reset cycles
`define OPLFR_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("oplfr checker: reset property failed");

`endif

FILE: rtl/oplfr_pkg.sv
// ----------------------------------------------------------------------------
// oplfr_pkg
// types and codes for the ordered list with push front and removals
// ----------------------------------------------------------------------------
`default_nettype none

package oplfr_pkg;

   localparam int DATA_W  = 32;
   localparam int POS_W   = 7;
   localparam int COUNT_W = 7;

   // operation codes
   typedef enum logic [1:0] {
      FUNC_PUSH_FRONT = 2'd0,
      FUNC_POP_FRONT  = 2'd1,
      FUNC_REMOVE_AT  = 2'd2,
      FUNC_POP_BACK   = 2'd3
   } func_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_EMPTY  = 2'd1,
      STATUS_BADPOS = 2'd2,
      STATUS_FULL   = 2'd3
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_EXEC,
      CTRL_RESP
   } ctrl_state_type;

   typedef struct packed {
      func_type                  func;
      logic signed [DATA_W-1:0]  value;
      logic [POS_W-1:0]          position;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  removed_value;
      logic [COUNT_W-1:0]        count;
      logic signed [DATA_W-1:0]  front_value;
   } rsp_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load_req;
      logic execute;
   } dp_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/oplfr_ctrl.sv
// ----------------------------------------------------------------------------
// oplfr_ctrl
// sequencer: takes a request word, runs the execute state, shows the result
// ----------------------------------------------------------------------------
`default_nettype none

module oplfr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   output logic                      rsp_strobe,
   output oplfr_pkg::dp_cmd_type     cmd
);

   oplfr_pkg::ctrl_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         oplfr_pkg::CTRL_IDLE: begin
            if (start) state_in = oplfr_pkg::CTRL_EXEC;
         end
         oplfr_pkg::CTRL_EXEC: begin
            state_in = oplfr_pkg::CTRL_RESP;
         end
         oplfr_pkg::CTRL_RESP: begin
            state_in = start ? oplfr_pkg::CTRL_EXEC : oplfr_pkg::CTRL_IDLE;
         end
         default: begin
            state_in = oplfr_pkg::CTRL_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy         = 1'b0;
      rsp_strobe   = 1'b0;
      cmd.load_req = 1'b0;
      cmd.execute  = 1'b0;
      unique case (state_ff)
         oplfr_pkg::CTRL_IDLE: begin
            cmd.load_req = start;
         end
         oplfr_pkg::CTRL_EXEC: begin
            busy        = 1'b1;
            cmd.execute = 1'b1;
         end
         oplfr_pkg::CTRL_RESP: begin
            rsp_strobe   = 1'b1;
            cmd.load_req = start;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oplfr_pkg::CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/oplfr_dpath.sv
// ----------------------------------------------------------------------------
// oplfr_dpath
// row of element cells that shift as one, element count and result register
// ----------------------------------------------------------------------------
`default_nettype none

module oplfr_dpath #(
   parameter int CAPACITY = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  oplfr_pkg::dp_cmd_type     cmd,
   input  oplfr_pkg::req_type        req_word,
   output oplfr_pkg::rsp_type        rsp_word
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int IW   = $clog2(CAPACITY);
   localparam int CMPW = (CW > oplfr_pkg::POS_W) ? CW : oplfr_pkg::POS_W;

   oplfr_pkg::req_type              req_ff;
   oplfr_pkg::rsp_type              rsp_ff, rsp_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic signed [oplfr_pkg::DATA_W-1:0] cell_ff [CAPACITY];

   logic [CMPW-1:0] pos_ext, cnt_ext, idx_ext, cnt_out_ext;
   logic [IW-1:0]   rm_idx;
   logic            is_full, is_empty, pos_ok;
   logic            do_insert, do_remove;
   oplfr_pkg::status_type status_c;

   // request register
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_word;
      end
   end

   // decode the request against the current count
   always_comb begin
      pos_ext   = CMPW'(req_ff.position);
      cnt_ext   = CMPW'(count_ff);
      is_full   = (count_ff == CW'(CAPACITY));
      is_empty  = (count_ff == '0);
      pos_ok    = (pos_ext != '0) && (pos_ext <= cnt_ext);
      status_c  = oplfr_pkg::STATUS_OK;
      do_insert = 1'b0;
      do_remove = 1'b0;
      idx_ext   = '0;
      unique case (req_ff.func)
         oplfr_pkg::FUNC_PUSH_FRONT: begin
            if (is_full) status_c = oplfr_pkg::STATUS_FULL;
            else         do_insert = 1'b1;
         end
         oplfr_pkg::FUNC_POP_FRONT: begin
            if (is_empty) status_c = oplfr_pkg::STATUS_EMPTY;
            else          do_remove = 1'b1;
         end
         oplfr_pkg::FUNC_REMOVE_AT: begin
            if (is_empty) begin
               status_c = oplfr_pkg::STATUS_EMPTY;
            end else if (!pos_ok) begin
               status_c = oplfr_pkg::STATUS_BADPOS;
            end else begin
               do_remove = 1'b1;
               idx_ext   = pos_ext - CMPW'(1);
            end
         end
         oplfr_pkg::FUNC_POP_BACK: begin
            if (is_empty) begin
               status_c = oplfr_pkg::STATUS_EMPTY;
            end else begin
               do_remove = 1'b1;
               idx_ext   = cnt_ext - CMPW'(1);
            end
         end
         default: begin
            status_c = oplfr_pkg::STATUS_OK;
         end
      endcase
      rm_idx = idx_ext[IW-1:0];
   end

   // count update
   always_comb begin
      count_in = count_ff;
      if (do_insert)      count_in = count_ff + CW'(1);
      else if (do_remove) count_in = count_ff - CW'(1);
      cnt_out_ext = CMPW'(count_in);
   end

   // result word
   always_comb begin
      rsp_in.status        = status_c;
      rsp_in.removed_value = do_remove ? cell_ff[rm_idx] : '0;
      rsp_in.count         = cnt_out_ext[oplfr_pkg::COUNT_W-1:0];
      if (count_in == '0)
         rsp_in.front_value = '0;
      else if (do_insert)
         rsp_in.front_value = req_ff.value;
      else if (do_remove && (rm_idx == '0))
         rsp_in.front_value = cell_ff[1];
      else
         rsp_in.front_value = cell_ff[0];
   end

   // element cells: shift toward the back on insert, close the gap on removal
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic signed [oplfr_pkg::DATA_W-1:0] from_front, from_back, cell_in;

      if (k == 0) begin : g_head
         assign from_front = req_ff.value;
      end else begin : g_body
         assign from_front = cell_ff[k-1];
      end

      if (k == CAPACITY - 1) begin : g_tail
         assign from_back = cell_ff[k];
      end else begin : g_inner
         assign from_back = cell_ff[k+1];
      end

      always_comb begin
         cell_in = cell_ff[k];
         if (do_insert)
            cell_in = from_front;
         else if (do_remove && (IW'(k) >= rm_idx))
            cell_in = from_back;
      end

      always_ff @(posedge clock) begin
         if (cmd.execute) begin
            cell_ff[k] <= cell_in;
         end
      end
   end

   // count and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/ordered_list_push_front_remove.sv
// ----------------------------------------------------------------------------
// ordered_list_push_front_remove
// a word is registered into the request register, executed in the EXEC state,
// and its result shown in the RESP state; a new word is taken while a result shows
// the pace is set by the execute state of the controller
// reset: synchronous, empties the list; element cells keep stale data
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_push_front_remove #(
   parameter int CAPACITY = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  oplfr_pkg::req_type        req_word,
   output logic                      rsp_strobe,
   output oplfr_pkg::rsp_type        rsp_word
);

   oplfr_pkg::dp_cmd_type cmd;

   // sequencer
   oplfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // list storage and result
   oplfr_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

endmodule

`default_nettype wire

FILE: rtl/oplfr_checker.sv
// ----------------------------------------------------------------------------
// oplfr_checker
// port level checks of the list block timing and result consistency
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_list_push_front_remove_defines.svh"

module oplfr_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               rsp_strobe,
   input oplfr_pkg::rsp_type      rsp_word
);

   logic empty_rsp;
   logic empty_clean;

   // an empty report and what it must carry
   assign empty_rsp   = rsp_strobe && (rsp_word.status == oplfr_pkg::STATUS_EMPTY);
   assign empty_clean = (rsp_word.count == '0) && (rsp_word.front_value == '0) &&
                        (rsp_word.removed_value == '0);

   // every accepted word gets its result strobe after the execute state
   `OPLFR_ASSERT(a_accept_to_rsp, (start && !busy) |-> ##2 rsp_strobe)

   // result strobes never show back to back
   `OPLFR_ASSERT(a_rsp_single, rsp_strobe |=> !rsp_strobe)

   // an empty report leaves nothing in the list
   `OPLFR_ASSERT(a_empty_rsp, empty_rsp |-> empty_clean)

   // reset leaves the block idle with no result
   `OPLFR_ASSERT_RST(a_reset_idle, reset |=> (!busy && !rsp_strobe))

endmodule

bind ordered_list_push_front_remove oplfr_checker u_checker (.*);

`default_nettype wire

FILE: test/ordered_list_push_front_remove_tb.sv
// ----------------------------------------------------------------------------
// ordered_list_push_front_remove_tb
// self-checking bench for the ordered list with push front and removals:
// a shadow copy of the list predicts status, removed value, count and front
// value for every accepted word, and each result strobe is matched in order
// against the oldest prediction; stimulus mixes directed corner words with
// fill, drain and mixed phases of random words under random start gaps
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// shadow copy of the list contents and the results still owed by the block
class list_shadow;
   localparam int DEPTH = 64;

   logic signed [31:0]   cells [DEPTH];
   int                   count;
   oplfr_pkg::rsp_type   pending_rsp [$];
   int                   errors;

   function new();
      count  = 0;
      errors = 0;
   endfunction

   function int pending();
      return pending_rsp.size();
   endfunction

   task report_mismatch(string msg);
      errors++;
      if (errors <= 100)
         $display("mismatch: %s", msg);
   endtask

   // apply one accepted word to the shadow list and queue the result it owes
   function void take_word(oplfr_pkg::req_type w);
      oplfr_pkg::rsp_type r;
      int                 slot;
      bit                 take;
      r        = '0;
      r.status = oplfr_pkg::STATUS_OK;
      take     = 1'b0;
      slot     = 0;
      if (w.func == oplfr_pkg::FUNC_PUSH_FRONT) begin
         if (count >= DEPTH) begin
            r.status = oplfr_pkg::STATUS_FULL;
         end else begin
            for (int k = count; k > 0; k--)
               cells[k] = cells[k-1];
            cells[0] = w.value;
            count++;
         end
      end else if (count == 0) begin
         // an empty list wins over any position check
         r.status = oplfr_pkg::STATUS_EMPTY;
      end else if (w.func == oplfr_pkg::FUNC_POP_FRONT) begin
         take = 1'b1;
         slot = 0;
      end else if (w.func == oplfr_pkg::FUNC_POP_BACK) begin
         take = 1'b1;
         slot = count - 1;
      end else if (w.position == 0 || int'(w.position) > count) begin
         r.status = oplfr_pkg::STATUS_BADPOS;
      end else begin
         take = 1'b1;
         slot = int'(w.position) - 1;
      end
      // close the gap left by the removed cell
      if (take) begin
         r.removed_value = cells[slot];
         for (int k = slot; k + 1 < count; k++)
            cells[k] = cells[k+1];
         count--;
      end
      r.count       = count[6:0];
      r.front_value = (count > 0) ? cells[0] : 32'sd0;
      pending_rsp.push_back(r);
   endfunction

   // compare one result strobe with the oldest prediction
   task match_rsp(oplfr_pkg::rsp_type got);
      oplfr_pkg::rsp_type want;
      if (pending_rsp.size() == 0) begin
         report_mismatch("result strobe with no word outstanding");
      end else begin
         want = pending_rsp.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
         if (got.removed_value !== want.removed_value)
            report_mismatch($sformatf("removed_value got %0d want %0d",
                                      got.removed_value, want.removed_value));
         if (got.count !== want.count)
            report_mismatch($sformatf("count got %0d want %0d", got.count, want.count));
         if (got.front_value !== want.front_value)
            report_mismatch($sformatf("front_value got %0d want %0d",
                                      got.front_value, want.front_value));
      end
   endtask
endclass

module ordered_list_push_front_remove_tb;

   localparam int LIST_DEPTH  = 64;
   localparam int RAND_WORDS  = 1000;
   localparam int STALL_LIMIT = 2000;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   oplfr_pkg::req_type req_word;
   logic               rsp_strobe;
   oplfr_pkg::rsp_type rsp_word;

   list_shadow shadow = new();
   int         stall_cycles;
   bit         no_gaps;
   int         sent;

   ordered_list_push_front_remove #(
      .CAPACITY (LIST_DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // idle cycles before a word: mostly none or short, now and then long
   function int pick_gap();
      int r;
      if (no_gaps)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function oplfr_pkg::req_type make_word(oplfr_pkg::func_type f,
                                          logic signed [31:0] v, logic [6:0] p);
      oplfr_pkg::req_type w;
      w.func     = f;
      w.value    = v;
      w.position = p;
      return w;
   endfunction

   // value with the extremes showing up often
   function logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // position mostly inside the list, sometimes zero or past the end
   function logic [6:0] pick_position();
      int r;
      r = $urandom_range(0, 99);
      if (shadow.count > 0 && r < 80)
         return 7'($urandom_range(1, shadow.count));
      if (r < 90)
         return 7'd0;
      return 7'($urandom_range(shadow.count + 1, 127));
   endfunction

   function oplfr_pkg::func_type pick_removal();
      return oplfr_pkg::func_type'($urandom_range(1, 3));
   endfunction

   // offer one word after a gap and hold it until the block takes it
   task send_word(oplfr_pkg::req_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      shadow.take_word(w);
      sent++;
   endtask

   task send_random(oplfr_pkg::func_type f);
      send_word(make_word(f, pick_value(), pick_position()));
   endtask

   // results are sampled at the edge that ends their strobe cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         shadow.match_rsp(rsp_word);
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL ordered_list_push_front_remove");
         $finish;
      end
   end

   initial begin
      int kind;
      int extra;
      int steps;
      reset        <= 1'b1;
      start        <= 1'b0;
      req_word     <= '0;
      no_gaps      = 1'b0;
      sent         = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // removals on an empty list, position checks come second
      send_word(make_word(oplfr_pkg::FUNC_POP_FRONT, 32'sd5, 7'd0));
      send_word(make_word(oplfr_pkg::FUNC_POP_BACK,  32'sd6, 7'd1));
      send_word(make_word(oplfr_pkg::FUNC_REMOVE_AT, 32'sd7, 7'd0));
      send_word(make_word(oplfr_pkg::FUNC_REMOVE_AT, 32'sd8, 7'd127));
      // single element: bad positions, then removal empties the list
      send_word(make_word(oplfr_pkg::FUNC_PUSH_FRONT, 32'sh7fff_ffff, 7'd0));
      send_word(make_word(oplfr_pkg::FUNC_REMOVE_AT,  32'sd0, 7'd0));
      send_word(make_word(oplfr_pkg::FUNC_REMOVE_AT,  32'sd0, 7'd2));
      send_word(make_word(oplfr_pkg::FUNC_REMOVE_AT,  32'sd0, 7'd1));
      send_word(make_word(oplfr_pkg::FUNC_PUSH_FRONT, 32'sh8000_0000, 7'd127));
      send_word(make_word(oplfr_pkg::FUNC_POP_FRONT,  -32'sd1, 7'd127));
      send_word(make_word(oplfr_pkg::FUNC_PUSH_FRONT, -32'sd1, 7'd64));
      send_word(make_word(oplfr_pkg::FUNC_POP_BACK,   32'sd0, 7'd0));
      // a few elements, removal from the middle and both ends
      send_word(make_word(oplfr_pkg::FUNC_PUSH_FRONT, 32'sd0, 7'd0));
      send_word(make_word(oplfr_pkg::FUNC_PUSH_FRONT, 32'sd1, 7'd0));
      send_word(make_word(oplfr_pkg::FUNC_PUSH_FRONT, -32'sd2, 7'd0));
      send_word(make_word(oplfr_pkg::FUNC_PUSH_FRONT, 32'sh5555_aaaa, 7'd0));
      send_word(make_word(oplfr_pkg::FUNC_REMOVE_AT,  32'sd0, 7'd2));
      send_word(make_word(oplfr_pkg::FUNC_REMOVE_AT,  32'sd0, 7'd4));
      send_word(make_word(oplfr_pkg::FUNC_REMOVE_AT,  32'sd0, 7'd3));
      send_word(make_word(oplfr_pkg::FUNC_REMOVE_AT,  32'sd0, 7'd127));
      send_word(make_word(oplfr_pkg::FUNC_POP_BACK,   32'sd0, 7'd0));
      send_word(make_word(oplfr_pkg::FUNC_POP_FRONT,  32'sd0, 7'd0));
      send_word(make_word(oplfr_pkg::FUNC_POP_FRONT,  32'sd0, 7'd0));

      // random phases: the first one fills the list to the top
      sent = 0;
      kind = 0;
      while (sent < RAND_WORDS) begin
         no_gaps = ($urandom_range(0, 9) < 3);
         steps   = 0;
         if (kind == 0) begin
            // fill until full, then a few refused pushes
            while (shadow.count < LIST_DEPTH && steps < 400) begin
               if ($urandom_range(0, 9) < 9)
                  send_random(oplfr_pkg::FUNC_PUSH_FRONT);
               else
                  send_random(pick_removal());
               steps++;
            end
            extra = $urandom_range(1, 3);
            repeat (extra) send_random(oplfr_pkg::FUNC_PUSH_FRONT);
         end else if (kind == 1) begin
            // drain until empty, then a few removals on nothing
            while (shadow.count > 0 && steps < 400) begin
               if ($urandom_range(0, 9) < 9)
                  send_random(pick_removal());
               else
                  send_random(oplfr_pkg::FUNC_PUSH_FRONT);
               steps++;
            end
            extra = $urandom_range(1, 3);
            repeat (extra) send_random(pick_removal());
         end else begin
            repeat (30) send_random(oplfr_pkg::func_type'($urandom_range(0, 3)));
         end
         kind = $urandom_range(0, 2);
      end

      // let the last results come out
      @(posedge clock);
      start <= 1'b0;
      while (shadow.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (shadow.errors == 0 && shadow.pending() == 0)
         $display("PASS ordered_list_push_front_remove");
      else
         $display("FAIL ordered_list_push_front_remove");
      $finish;
   end

endmodule
